/* rtl/d2q9_pkg.sv */
// ----------------------------------------------------------------------------
// d2q9_pkg
// Shared types, constants and saturating fixed point helpers for the D2Q9
// collision pipeline.
// ----------------------------------------------------------------------------
package d2q9_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int N_DIR          = 9;
  localparam int N_IN           = 11;
  localparam int RATE_BITS      = 16;
  localparam int RATE_W         = 18;
  localparam int CFG_INDEX_W    = 8;
  localparam int LANE_STAGES    = 8;
  localparam int WIDE           = 136;

  localparam logic [RATE_W-1:0] RELAX_RESET = 18'd65536;
  localparam logic [RATE_W-1:0] KEEP_RESET  = 18'd0;
  localparam logic [RATE_W-1:0] GAIN_RESET  = 18'd98304;

  localparam int DIR_X [N_DIR] = '{0, 1, 0, -1, 0, 1, -1, -1, 1};
  localparam int DIR_Y [N_DIR] = '{0, 0, 1, 0, -1, 1, 1, -1, -1};

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_RELAX_RATE = 8'd0,
    REG_KEEP_RATE  = 8'd1,
    REG_FORCE_GAIN = 8'd2,
    REG_GRAVITY_X  = 8'd3,
    REG_GRAVITY_Y  = 8'd4
  } cfg_reg_t;

  typedef logic signed [WIDE-1:0] wide_t;

  function automatic int bytes_up(input int bits);
    return ((bits + 7) / 8) * 8;
  endfunction

  // clamp to a signed word of w bits
  function automatic wide_t sat(input wide_t v, input int w);
    wide_t hi;
    wide_t lo;
    hi = (wide_t'(1) <<< (w - 1)) - wide_t'(1);
    lo = -hi - wide_t'(1);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic wide_t add_sat(input wide_t a, input wide_t b, input int w);
    return sat(a + b, w);
  endfunction

  function automatic wide_t sub_sat(input wide_t a, input wide_t b, input int w);
    return sat(a - b, w);
  endfunction

  // exact product shifted right (floor) then clamped
  function automatic wide_t shr_sat(input wide_t p, input int s, input int w);
    return sat(p >>> s, w);
  endfunction

  // projection of a vector onto a lattice direction
  function automatic wide_t proj(input int dx, input int dy, input wide_t vx,
                                 input wide_t vy, input int w);
    wide_t t;
    t = '0;
    if (dx > 0) t = add_sat(t, vx, w);
    if (dx < 0) t = sub_sat(t, vx, w);
    if (dy > 0) t = add_sat(t, vy, w);
    if (dy < 0) t = sub_sat(t, vy, w);
    return t;
  endfunction

endpackage

/* rtl/d2q9_front.sv */
// ----------------------------------------------------------------------------
// d2q9_front
// Density, momentum and total force of one cell, three register stages.
// ----------------------------------------------------------------------------
module d2q9_front #(
  parameter int W    = 32,
  parameter int FRAC = 28
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [8:0][W-1:0]          dist_i,
  input  logic signed [W-1:0]        sfx,
  input  logic signed [W-1:0]        sfy,
  input  logic signed [W-1:0]        gx,
  input  logic signed [W-1:0]        gy,
  output logic [8:0][W-1:0]          dist_o,
  output logic signed [W-1:0]        rho_o,
  output logic signed [W-1:0]        fx_o,
  output logic signed [W-1:0]        fy_o,
  output logic signed [W-1:0]        mx_o,
  output logic signed [W-1:0]        my_o,
  output logic                       fault_o
);
  import d2q9_pkg::*;

  logic [8:0][W-1:0]   r1_dist, r2_dist;
  logic signed [W-1:0] r1_rho, r1_mx, r1_my, r1_sfx, r1_sfy;
  logic signed [W-1:0] r2_rho, r2_mx, r2_my, r2_sfx, r2_sfy;
  logic signed [2*W-1:0] r2_pgx, r2_pgy;
  logic signed [W-1:0] rho_c, mx_c, my_c;
  wide_t               fxw, fyw;

  always_comb begin
    wide_t acc, ax, ay;
    acc = '0;
    ax  = '0;
    ay  = '0;
    for (int i = 0; i < N_DIR; i++) begin
      acc = add_sat(acc, wide_t'($signed(dist_i[i])), W);
      if (DIR_X[i] > 0) ax = add_sat(ax, wide_t'($signed(dist_i[i])), W);
      if (DIR_X[i] < 0) ax = sub_sat(ax, wide_t'($signed(dist_i[i])), W);
      if (DIR_Y[i] > 0) ay = add_sat(ay, wide_t'($signed(dist_i[i])), W);
      if (DIR_Y[i] < 0) ay = sub_sat(ay, wide_t'($signed(dist_i[i])), W);
    end
    rho_c = W'(acc);
    mx_c  = W'(ax);
    my_c  = W'(ay);
  end

  always_comb begin
    fxw = add_sat(shr_sat(wide_t'(r2_pgx), FRAC, W), wide_t'(r2_sfx), W);
    fyw = add_sat(shr_sat(wide_t'(r2_pgy), FRAC, W), wide_t'(r2_sfy), W);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r1_dist <= dist_i;
      r1_rho  <= rho_c;
      r1_mx   <= mx_c;
      r1_my   <= my_c;
      r1_sfx  <= sfx;
      r1_sfy  <= sfy;
      r2_dist <= r1_dist;
      r2_rho  <= r1_rho;
      r2_mx   <= r1_mx;
      r2_my   <= r1_my;
      r2_sfx  <= r1_sfx;
      r2_sfy  <= r1_sfy;
      r2_pgx  <= gx * r1_rho;
      r2_pgy  <= gy * r1_rho;
      dist_o  <= r2_dist;
      rho_o   <= r2_rho;
      fx_o    <= W'(fxw);
      fy_o    <= W'(fyw);
      mx_o    <= W'(add_sat(wide_t'(r2_mx), fxw >>> 1, W));
      my_o    <= W'(add_sat(wide_t'(r2_my), fyw >>> 1, W));
      fault_o <= (r2_rho <= 0);
    end
  end

endmodule

/* rtl/d2q9_div.sv */
// ----------------------------------------------------------------------------
// d2q9_div
// Pipelined restoring divider, one quotient bit per stage, for num / den
// scaled by 2^FRAC.
// ----------------------------------------------------------------------------
module d2q9_div #(
  parameter int W    = 32,
  parameter int FRAC = 28,
  localparam int QW  = W + FRAC
) (
  input  logic          clk,
  input  logic          en,
  input  logic [W-1:0]  num,
  input  logic          neg,
  input  logic [W-2:0]  den,
  output logic [QW-1:0] quo,
  output logic          neg_o
);

  logic [W-2:0]  rem_r [QW];
  logic [QW-1:0] dvd_r [QW];
  logic [QW-1:0] quo_r [QW];
  logic [W-2:0]  den_r [QW];
  logic          neg_r [QW];
  logic [W-2:0]  rem_n [QW];
  logic [QW-1:0] dvd_n [QW];
  logic [QW-1:0] quo_n [QW];
  logic [W-2:0]  den_n [QW];
  logic          neg_n [QW];

  always_comb begin
    logic [W-2:0]  s_rem;
    logic [QW-1:0] s_dvd;
    logic [QW-1:0] s_quo;
    logic [W-2:0]  s_den;
    logic          s_neg;
    logic [W-1:0]  t;
    logic          ge;
    for (int k = 0; k < QW; k++) begin
      if (k == 0) begin
        s_rem = '0;
        s_dvd = {num, {FRAC{1'b0}}};
        s_quo = '0;
        s_den = den;
        s_neg = neg;
      end else begin
        s_rem = rem_r[k-1];
        s_dvd = dvd_r[k-1];
        s_quo = quo_r[k-1];
        s_den = den_r[k-1];
        s_neg = neg_r[k-1];
      end
      t  = {s_rem, s_dvd[QW-1]};
      ge = (t >= {1'b0, s_den});
      rem_n[k] = ge ? (t[W-2:0] - s_den) : t[W-2:0];
      dvd_n[k] = {s_dvd[QW-2:0], 1'b0};
      quo_n[k] = {s_quo[QW-2:0], ge};
      den_n[k] = s_den;
      neg_n[k] = s_neg;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < QW; k++) begin
        rem_r[k] <= rem_n[k];
        dvd_r[k] <= dvd_n[k];
        quo_r[k] <= quo_n[k];
        den_r[k] <= den_n[k];
        neg_r[k] <= neg_n[k];
      end
    end
  end

  assign quo   = quo_r[QW-1];
  assign neg_o = neg_r[QW-1];

endmodule

/* rtl/d2q9_lane.sv */
// ----------------------------------------------------------------------------
// d2q9_lane
// Equilibrium, forcing term and relaxation for one lattice direction,
// eight register stages.
// ----------------------------------------------------------------------------
module d2q9_lane #(
  parameter int W    = 32,
  parameter int FRAC = 28,
  parameter int DIR  = 0
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [W-1:0]      ux,
  input  logic signed [W-1:0]      uy,
  input  logic signed [W-1:0]      fx,
  input  logic signed [W-1:0]      fy,
  input  logic signed [W-1:0]      usq,
  input  logic signed [W-1:0]      uf,
  input  logic signed [W-1:0]      rho,
  input  logic signed [W-1:0]      dist_i,
  input  logic [17:0]              relax_rate,
  input  logic signed [17:0]       keep_rate,
  input  logic [17:0]              force_gain,
  output logic signed [W-1:0]      res
);
  import d2q9_pkg::*;

  localparam wide_t ONE_Q  = wide_t'(1) <<< FRAC;
  localparam wide_t W_REST = ((wide_t'(8) <<< FRAC) + wide_t'(9)) / wide_t'(18);
  localparam wide_t W_AXIS = ((wide_t'(2) <<< FRAC) + wide_t'(9)) / wide_t'(18);
  localparam wide_t W_DIAG = ((wide_t'(2) <<< FRAC) + wide_t'(36)) / wide_t'(72);
  localparam wide_t WT     = (DIR == 0) ? W_REST : ((DIR < 5) ? W_AXIS : W_DIAG);
  localparam logic signed [W-1:0] WT_W = W'(WT);

  logic signed [W-1:0]   l0_cu, l0_cf, l0_usq, l0_uf, l0_rho, l0_dist;
  logic signed [2*W-1:0] l1_pcc, l1_pccf, l1_prw, l1_pkf, l1_pfgw;
  logic signed [W-1:0]   l1_cu3, l1_us15, l1_frc0;
  logic signed [W-1:0]   l2_cc9, l2_cuf3, l2_rw, l2_fgw, l2_kf, l2_cu3, l2_us15, l2_frc0;
  logic signed [W-1:0]   l3_poly, l3_frc, l3_rw, l3_fgw, l3_kf;
  logic signed [2*W-1:0] l4_peq, l4_pfr;
  logic signed [W-1:0]   l4_kf;
  logic signed [W-1:0]   l5_eq, l5_frv, l5_kf;
  logic signed [2*W-1:0] l6_prr;
  logic signed [W-1:0]   l6_frv, l6_kf;

  wide_t cc_w, cuf_w;

  always_comb begin
    cc_w  = shr_sat(wide_t'(l1_pcc), FRAC, W);
    cuf_w = shr_sat(wide_t'(l1_pccf), FRAC, W);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // projections
      l0_cu   <= W'(proj(DIR_X[DIR], DIR_Y[DIR], wide_t'(ux), wide_t'(uy), W));
      l0_cf   <= W'(proj(DIR_X[DIR], DIR_Y[DIR], wide_t'(fx), wide_t'(fy), W));
      l0_usq  <= usq;
      l0_uf   <= uf;
      l0_rho  <= rho;
      l0_dist <= dist_i;
      // raw products
      l1_pcc  <= l0_cu * l0_cu;
      l1_pccf <= l0_cu * l0_cf;
      l1_prw  <= l0_rho * WT_W;
      l1_pkf  <= keep_rate * l0_dist;
      l1_pfgw <= $signed({1'b0, force_gain}) * WT_W;
      l1_cu3  <= W'(sat(wide_t'(l0_cu) + (wide_t'(l0_cu) <<< 1), W));
      l1_us15 <= W'(sat((wide_t'(l0_usq) + (wide_t'(l0_usq) <<< 1)) >>> 1, W));
      l1_frc0 <= W'(sub_sat(wide_t'(l0_cf), wide_t'(l0_uf), W));
      // scaled terms
      l2_cc9  <= W'(sat(((cc_w <<< 3) + cc_w) >>> 1, W));
      l2_cuf3 <= W'(sat((cuf_w <<< 1) + cuf_w, W));
      l2_rw   <= W'(shr_sat(wide_t'(l1_prw), FRAC, W));
      l2_fgw  <= W'(shr_sat(wide_t'(l1_pfgw), RATE_BITS, W));
      l2_kf   <= W'(shr_sat(wide_t'(l1_pkf), RATE_BITS, W));
      l2_cu3  <= l1_cu3;
      l2_us15 <= l1_us15;
      l2_frc0 <= l1_frc0;
      // polynomial and force sum
      l3_poly <= W'(sub_sat(add_sat(add_sat(ONE_Q, wide_t'(l2_cu3), W),
                                    wide_t'(l2_cc9), W), wide_t'(l2_us15), W));
      l3_frc  <= W'(add_sat(wide_t'(l2_frc0), wide_t'(l2_cuf3), W));
      l3_rw   <= l2_rw;
      l3_fgw  <= l2_fgw;
      l3_kf   <= l2_kf;
      l4_peq  <= l3_rw * l3_poly;
      l4_pfr  <= l3_fgw * l3_frc;
      l4_kf   <= l3_kf;
      l5_eq   <= W'(shr_sat(wide_t'(l4_peq), FRAC, W));
      l5_frv  <= W'(shr_sat(wide_t'(l4_pfr), FRAC, W));
      l5_kf   <= l4_kf;
      l6_prr  <= $signed({1'b0, relax_rate}) * l5_eq;
      l6_frv  <= l5_frv;
      l6_kf   <= l5_kf;
      res     <= W'(add_sat(add_sat(wide_t'(l6_kf),
                                    shr_sat(wide_t'(l6_prr), RATE_BITS, W), W),
                            wide_t'(l6_frv), W));
    end
  end

endmodule

/* rtl/d2q9_bgk_collision_forced_top.sv */
// ----------------------------------------------------------------------------
// d2q9_bgk_collision_forced_top
// D2Q9 BGK collision with Guo forcing, one lattice cell per transfer.
//
// channel  dir  fields
// s_*      in   tdata: dist_rest..dist_southeast, spread_force_x, spread_force_y
// m_*      out  tdata: new_rest..new_southeast; tuser: density_fault
// cfg_*    in   relax_rate, keep_rate, force_gain, gravity_x, gravity_y
//
// one cell per cycle sustained while m_tready keeps up; cells pass the front,
// the bit-per-stage velocity divider and then the nine direction lanes
// reset clears the stage valid bits and loads the register defaults
// a held output freezes the whole pipeline, s_tready follows it
// ----------------------------------------------------------------------------
module d2q9_bgk_collision_forced_top #(
  parameter int DATA_WIDTH = d2q9_pkg::DATA_WIDTH_DEF
) (
  input  logic                                            clk,
  input  logic                                            rst,
  input  logic                                            s_tvalid,
  output logic                                            s_tready,
  // dist_rest .. dist_southeast, spread_force_x, spread_force_y
  input  logic [d2q9_pkg::bytes_up(11*DATA_WIDTH)-1:0]    s_tdata,
  output logic                                            m_tvalid,
  input  logic                                            m_tready,
  // new_rest .. new_southeast
  output logic [d2q9_pkg::bytes_up(9*DATA_WIDTH)-1:0]     m_tdata,
  // density_fault
  output logic                                            m_tuser,
  input  logic                                            cfg_we,
  input  logic [d2q9_pkg::CFG_INDEX_W-1:0]                cfg_index,
  input  logic [DATA_WIDTH-1:0]                           cfg_data
);
  import d2q9_pkg::*;

  localparam int W    = DATA_WIDTH;
  localparam int FRAC = W - 4;
  localparam int QW   = W + FRAC;
  localparam int LAT  = 3 + QW + 3 + LANE_STAGES + 1;

  logic adv;
  logic [LAT-1:0] vld;

  logic [17:0]         relax_rate, force_gain;
  logic signed [17:0]  keep_rate;
  logic signed [W-1:0] gravity_x, gravity_y;

  logic [8:0][W-1:0]   in_dist;
  logic [8:0][W-1:0]   fr_dist;
  logic signed [W-1:0] fr_rho, fr_fx, fr_fy, fr_mx, fr_my;
  logic                fr_fault;

  logic [W-1:0]  num_x, num_y;
  logic [W-2:0]  den;
  logic [QW-1:0] qx, qy;
  logic          nx, ny;

  logic [8:0][W-1:0]   dl_dist  [QW];
  logic signed [W-1:0] dl_rho   [QW];
  logic signed [W-1:0] dl_fx    [QW];
  logic signed [W-1:0] dl_fy    [QW];
  logic                dl_fault [QW];

  logic [8:0][W-1:0]     e1_dist, e2_dist, e3_dist;
  logic signed [W-1:0]   e1_rho, e1_fx, e1_fy, e1_ux, e1_uy;
  logic signed [W-1:0]   e2_rho, e2_fx, e2_fy, e2_ux, e2_uy;
  logic signed [W-1:0]   e3_rho, e3_fx, e3_fy, e3_ux, e3_uy, e3_usq, e3_uf;
  logic                  e1_fault, e2_fault, e3_fault;
  logic signed [2*W-1:0] e2_pxx, e2_pyy, e2_pxf, e2_pyf;

  logic [LANE_STAGES-1:0] ln_fault;
  logic signed [W-1:0]    lane_res [N_DIR];
  logic [W-1:0]           out_d    [N_DIR];

  wide_t ux_w, uy_w;

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;
  assign m_tvalid = vld[LAT-1];

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      relax_rate <= RELAX_RESET;
      keep_rate  <= KEEP_RESET;
      force_gain <= GAIN_RESET;
      gravity_x  <= '0;
      gravity_y  <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_RELAX_RATE: relax_rate <= cfg_data[17:0];
        REG_KEEP_RATE:  keep_rate  <= cfg_data[17:0];
        REG_FORCE_GAIN: force_gain <= cfg_data[17:0];
        REG_GRAVITY_X:  gravity_x  <= cfg_data;
        REG_GRAVITY_Y:  gravity_y  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end

  always_comb begin
    for (int i = 0; i < N_DIR; i++) in_dist[i] = s_tdata[i*W +: W];
  end

  d2q9_front #(.W(W), .FRAC(FRAC)) u_front (
    .clk     (clk),
    .en      (adv),
    .dist_i  (in_dist),
    .sfx     (s_tdata[9*W +: W]),
    .sfy     (s_tdata[10*W +: W]),
    .gx      (gravity_x),
    .gy      (gravity_y),
    .dist_o  (fr_dist),
    .rho_o   (fr_rho),
    .fx_o    (fr_fx),
    .fy_o    (fr_fy),
    .mx_o    (fr_mx),
    .my_o    (fr_my),
    .fault_o (fr_fault)
  );

  assign num_x = fr_mx[W-1] ? (~fr_mx + 1'b1) : fr_mx;
  assign num_y = fr_my[W-1] ? (~fr_my + 1'b1) : fr_my;
  assign den   = fr_fault ? (W-1)'(1) : fr_rho[W-2:0];

  d2q9_div #(.W(W), .FRAC(FRAC)) u_div_x (
    .clk(clk), .en(adv), .num(num_x), .neg(fr_mx[W-1]), .den(den),
    .quo(qx), .neg_o(nx)
  );

  d2q9_div #(.W(W), .FRAC(FRAC)) u_div_y (
    .clk(clk), .en(adv), .num(num_y), .neg(fr_my[W-1]), .den(den),
    .quo(qy), .neg_o(ny)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      dl_dist[0]  <= fr_dist;
      dl_rho[0]   <= fr_rho;
      dl_fx[0]    <= fr_fx;
      dl_fy[0]    <= fr_fy;
      dl_fault[0] <= fr_fault;
      for (int k = 1; k < QW; k++) begin
        dl_dist[k]  <= dl_dist[k-1];
        dl_rho[k]   <= dl_rho[k-1];
        dl_fx[k]    <= dl_fx[k-1];
        dl_fy[k]    <= dl_fy[k-1];
        dl_fault[k] <= dl_fault[k-1];
      end
    end
  end

  always_comb begin
    ux_w = nx ? -wide_t'({1'b0, qx}) : wide_t'({1'b0, qx});
    uy_w = ny ? -wide_t'({1'b0, qy}) : wide_t'({1'b0, qy});
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e1_ux    <= W'(sat(ux_w, W));
      e1_uy    <= W'(sat(uy_w, W));
      e1_dist  <= dl_dist[QW-1];
      e1_rho   <= dl_rho[QW-1];
      e1_fx    <= dl_fx[QW-1];
      e1_fy    <= dl_fy[QW-1];
      e1_fault <= dl_fault[QW-1];

      e2_pxx   <= e1_ux * e1_ux;
      e2_pyy   <= e1_uy * e1_uy;
      e2_pxf   <= e1_ux * e1_fx;
      e2_pyf   <= e1_uy * e1_fy;
      e2_ux    <= e1_ux;
      e2_uy    <= e1_uy;
      e2_dist  <= e1_dist;
      e2_rho   <= e1_rho;
      e2_fx    <= e1_fx;
      e2_fy    <= e1_fy;
      e2_fault <= e1_fault;

      e3_usq   <= W'(add_sat(shr_sat(wide_t'(e2_pxx), FRAC, W),
                             shr_sat(wide_t'(e2_pyy), FRAC, W), W));
      e3_uf    <= W'(add_sat(shr_sat(wide_t'(e2_pxf), FRAC, W),
                             shr_sat(wide_t'(e2_pyf), FRAC, W), W));
      e3_ux    <= e2_ux;
      e3_uy    <= e2_uy;
      e3_dist  <= e2_dist;
      e3_rho   <= e2_rho;
      e3_fx    <= e2_fx;
      e3_fy    <= e2_fy;
      e3_fault <= e2_fault;

      ln_fault <= {ln_fault[LANE_STAGES-2:0], e3_fault};
    end
  end

  for (genvar i = 0; i < N_DIR; i++) begin : g_lane
    d2q9_lane #(.W(W), .FRAC(FRAC), .DIR(i)) u_lane (
      .clk        (clk),
      .en         (adv),
      .ux         (e3_ux),
      .uy         (e3_uy),
      .fx         (e3_fx),
      .fy         (e3_fy),
      .usq        (e3_usq),
      .uf         (e3_uf),
      .rho        (e3_rho),
      .dist_i     (e3_dist[i]),
      .relax_rate (relax_rate),
      .keep_rate  (keep_rate),
      .force_gain (force_gain),
      .res        (lane_res[i])
    );
  end

  // merge lanes, zero on density fault
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < N_DIR; i++) begin
        out_d[i] <= ln_fault[LANE_STAGES-1] ? '0 : lane_res[i];
      end
      m_tuser <= ln_fault[LANE_STAGES-1];
    end
  end

  always_comb begin
    m_tdata = '0;
    for (int i = 0; i < N_DIR; i++) m_tdata[i*W +: W] = out_d[i];
  end

endmodule

/* rtl/d2q9_check.sv */
// ----------------------------------------------------------------------------
// d2q9_check
// Port-level checks for the collision block, bound to the top level.
// ----------------------------------------------------------------------------
module d2q9_check #(
  parameter int DATA_WIDTH = d2q9_pkg::DATA_WIDTH_DEF
) (
  input logic                                          clk,
  input logic                                          rst,
  input logic                                          s_tvalid,
  input logic                                          s_tready,
  input logic [d2q9_pkg::bytes_up(11*DATA_WIDTH)-1:0]  s_tdata,
  input logic                                          m_tvalid,
  input logic                                          m_tready,
  input logic [d2q9_pkg::bytes_up(9*DATA_WIDTH)-1:0]   m_tdata,
  input logic                                          m_tuser,
  input logic                                          cfg_we,
  input logic [d2q9_pkg::CFG_INDEX_W-1:0]              cfg_index,
  input logic [DATA_WIDTH-1:0]                         cfg_data
);

  // pipeline empty after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // faulted cells carry all-zero distributions
  a_fault_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("nonzero data with density fault");

  // input side never blocked while the output register is empty
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  // stalled output holds until transfer
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output changed while stalled");

endmodule

bind d2q9_bgk_collision_forced_top d2q9_check #(.DATA_WIDTH(DATA_WIDTH)) u_check (.*);

/* verif/d2q9_collision_checker.sv */
// ----------------------------------------------------------------------------
// d2q9_collision_checker
// Watches the cell, result and register channels of the D2Q9 BGK collision
// block. It predicts the relaxed distributions of every accepted cell, queues
// them and compares each result transfer field by field in arrival order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module d2q9_collision_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [351:0] s_tdata,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [287:0] m_tdata,
  input  logic         m_tuser,
  input  logic         cfg_we,
  input  logic [7:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  output int           errors,
  output int           outstanding,
  output int           results_seen,
  output int           faults_seen
);
  import d2q9_pkg::*;

  typedef logic signed [127:0] acc_t;
  typedef struct {
    logic [287:0] dists;
    logic         fault;
  } cell_result_t;

  localparam int FRAC = 28;
  localparam acc_t WORD_MAX = acc_t'(64'sh7fffffff);
  localparam acc_t WORD_MIN = -WORD_MAX - 1;
  localparam acc_t ONE_Q    = acc_t'(64'd1 << FRAC);
  localparam acc_t W_REST   = acc_t'(((64'd8 << FRAC) + 9) / 18);
  localparam acc_t W_AXIS   = acc_t'(((64'd2 << FRAC) + 9) / 18);
  localparam acc_t W_DIAG   = acc_t'(((64'd2 << FRAC) + 36) / 72);

  logic [17:0] relax_rate, keep_rate, force_gain;
  logic [31:0] gravity_x, gravity_y;
  cell_result_t expected_cells[$];

  function automatic acc_t clamp(input acc_t v);
    if (v > WORD_MAX) return WORD_MAX;
    if (v < WORD_MIN) return WORD_MIN;
    return v;
  endfunction

  function automatic acc_t sadd(input acc_t a, input acc_t b);
    return clamp(a + b);
  endfunction

  function automatic acc_t ssub(input acc_t a, input acc_t b);
    return clamp(a - b);
  endfunction

  function automatic acc_t smul(input acc_t a, input acc_t b, input int s);
    acc_t p;
    p = a * b;
    return clamp(p >>> s);
  endfunction

  function automatic acc_t sdiv(input acc_t j, input acc_t r);
    logic neg;
    acc_t n, q, lim;
    neg = j < 0;
    n = neg ? -j : j;
    q = (n <<< FRAC) / r;
    lim = WORD_MAX + (neg ? 1 : 0);
    if (q > lim) return neg ? WORD_MIN : WORD_MAX;
    return neg ? -q : q;
  endfunction

  function automatic acc_t project(input int i, input acc_t vx, input acc_t vy);
    acc_t t;
    t = 0;
    if (DIR_X[i] > 0) t = sadd(t, vx);
    if (DIR_X[i] < 0) t = ssub(t, vx);
    if (DIR_Y[i] > 0) t = sadd(t, vy);
    if (DIR_Y[i] < 0) t = ssub(t, vy);
    return t;
  endfunction

  function automatic cell_result_t collide(input logic [351:0] d);
    cell_result_t r;
    acc_t f[9];
    acc_t rho, mx, my, fx, fy, ux, uy, usq, uf, kr, rr, fg;
    acc_t w, cu, cf, poly, eq, frc, res;
    r.dists = '0;
    r.fault = 1'b0;
    rho = 0;
    mx = 0;
    my = 0;
    kr = acc_t'($signed(keep_rate));
    rr = acc_t'(relax_rate);
    fg = acc_t'(force_gain);
    for (int i = 0; i < 9; i++) begin
      f[i] = acc_t'($signed(d[32*i +: 32]));
      rho = sadd(rho, f[i]);
    end
    if (rho <= 0) begin
      r.fault = 1'b1;
      return r;
    end
    fx = sadd(smul(acc_t'($signed(gravity_x)), rho, FRAC), acc_t'($signed(d[288 +: 32])));
    fy = sadd(smul(acc_t'($signed(gravity_y)), rho, FRAC), acc_t'($signed(d[320 +: 32])));
    for (int i = 0; i < 9; i++) begin
      if (DIR_X[i] > 0) mx = sadd(mx, f[i]);
      if (DIR_X[i] < 0) mx = ssub(mx, f[i]);
      if (DIR_Y[i] > 0) my = sadd(my, f[i]);
      if (DIR_Y[i] < 0) my = ssub(my, f[i]);
    end
    mx = sadd(mx, smul(fx, 1, 1));
    my = sadd(my, smul(fy, 1, 1));
    ux = sdiv(mx, rho);
    uy = sdiv(my, rho);
    usq = sadd(smul(ux, ux, FRAC), smul(uy, uy, FRAC));
    uf = sadd(smul(ux, fx, FRAC), smul(uy, fy, FRAC));
    for (int i = 0; i < 9; i++) begin
      w = (i == 0) ? W_REST : ((i < 5) ? W_AXIS : W_DIAG);
      cu = project(i, ux, uy);
      cf = project(i, fx, fy);
      poly = sadd(ONE_Q, smul(cu, 3, 0));
      poly = sadd(poly, smul(smul(cu, cu, FRAC), 9, 1));
      poly = ssub(poly, smul(usq, 3, 1));
      eq = smul(smul(rho, w, FRAC), poly, FRAC);
      frc = ssub(cf, uf);
      frc = sadd(frc, smul(smul(cu, cf, FRAC), 3, 0));
      frc = smul(smul(fg, w, RATE_BITS), frc, FRAC);
      res = sadd(smul(kr, f[i], RATE_BITS), smul(rr, eq, RATE_BITS));
      res = sadd(res, frc);
      r.dists[32*i +: 32] = res[31:0];
    end
    return r;
  endfunction

  task automatic report(input string what, input int lane, input logic [31:0] got,
                        input logic [31:0] want);
    $display("mismatch at %0t: %s lane %0d got %h expected %h", $realtime, what, lane,
             got, want);
    errors++;
  endtask

  assign outstanding = expected_cells.size();

  initial begin
    errors = 0;
    results_seen = 0;
    faults_seen = 0;
  end

  always @(posedge clk) begin
    cell_result_t want;
    if (rst) begin
      relax_rate = RELAX_RESET;
      keep_rate  = KEEP_RESET;
      force_gain = GAIN_RESET;
      gravity_x  = '0;
      gravity_y  = '0;
      expected_cells.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_RELAX_RATE: relax_rate = cfg_data[17:0];
          REG_KEEP_RATE:  keep_rate  = cfg_data[17:0];
          REG_FORCE_GAIN: force_gain = cfg_data[17:0];
          REG_GRAVITY_X:  gravity_x  = cfg_data;
          REG_GRAVITY_Y:  gravity_y  = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) expected_cells.push_back(collide(s_tdata));
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (m_tuser) faults_seen++;
        if (expected_cells.size() == 0) begin
          report("unexpected transfer", 0, m_tdata[31:0], 32'h0);
        end else begin
          want = expected_cells.pop_front();
          for (int i = 0; i < 9; i++)
            if (m_tdata[32*i +: 32] !== want.dists[32*i +: 32])
              report("distribution", i, m_tdata[32*i +: 32], want.dists[32*i +: 32]);
          if (m_tuser !== want.fault)
            report("density_fault", 9, 32'(m_tuser), 32'(want.fault));
        end
      end
    end
  end

endmodule

/* verif/tb_d2q9_bgk_collision_forced_top.sv */
// ----------------------------------------------------------------------------
// tb_d2q9_bgk_collision_forced_top
// Stimulus for the D2Q9 BGK collision block: directed corner cells, then
// near-equilibrium, raw random and corner cells over several register settings, with
// random idling on both sides, a long output stall and drain pauses.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_d2q9_bgk_collision_forced_top;
  import d2q9_pkg::*;

  localparam logic [7:0] REG_UNUSED = 8'd5;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 80;
  localparam int CELLS_PER_PHASE = 180;
  localparam logic [31:0] Q_MAX = 32'h7fffffff;
  localparam logic [31:0] Q_MIN = 32'h80000000;
  localparam logic [31:0] Q_ONE = 32'h10000000;

  logic         clk, rst;
  logic         s_tvalid, s_tready, m_tvalid, m_tready, m_tuser;
  logic [351:0] s_tdata;
  logic [287:0] m_tdata;
  logic         cfg_we;
  logic [7:0]   cfg_index;
  logic [31:0]  cfg_data;
  int           errors, outstanding, results_seen, faults_seen;
  int           cells_sent, idle_cycles;
  logic         no_idle, hold_req;

  d2q9_bgk_collision_forced_top dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  d2q9_collision_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .outstanding(outstanding),
    .results_seen(results_seen), .faults_seen(faults_seen)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_tready = 1'b0;
        repeat (400) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        m_tready = no_idle || ($urandom_range(99) >= 12);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d results pending", outstanding);
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [7:0] idx, input logic [31:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic drain();
    s_tvalid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic send_cell(input logic [351:0] d);
    if (!no_idle && $urandom_range(99) < 12) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = d;
    do @(posedge clk); while (!s_tready);
    cells_sent++;
    @(negedge clk);
  endtask

  function automatic logic [31:0] small_signed(input int span);
    return 32'($signed($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic logic [351:0] near_equilibrium();
    logic [351:0] d;
    logic [63:0] rho;
    rho = 64'(Q_ONE / 2) + 64'($urandom_range(0, 3 * (Q_ONE / 2)));
    for (int i = 0; i < 9; i++)
      d[32*i +: 32] = 32'(rho * ((i == 0) ? 16 : ((i < 5) ? 4 : 1)) / 36)
                      + small_signed(1 << 22);
    d[288 +: 32] = small_signed(1 << 20);
    d[320 +: 32] = small_signed(1 << 20);
    return d;
  endfunction

  function automatic logic [351:0] corner_cell();
    logic [351:0] d;
    for (int i = 0; i < 11; i++)
      case ($urandom_range(3))
        0: d[32*i +: 32] = Q_MAX;
        1: d[32*i +: 32] = Q_MIN;
        2: d[32*i +: 32] = '0;
        default: d[32*i +: 32] = $urandom;
      endcase
    return d;
  endfunction

  function automatic logic [351:0] random_cell();
    logic [351:0] d;
    int pick;
    pick = $urandom_range(99);
    if (pick < 70) return near_equilibrium();
    if (pick < 85) begin
      for (int i = 0; i < 11; i++) d[32*i +: 32] = $urandom;
      return d;
    end
    return corner_cell();
  endfunction

  function automatic logic [351:0] uniform_cell(input logic [31:0] f, input logic [31:0] g);
    logic [351:0] d;
    for (int i = 0; i < 9; i++) d[32*i +: 32] = f;
    d[288 +: 32] = g;
    d[320 +: 32] = g;
    return d;
  endfunction

  task automatic directed_cells();
    logic [351:0] d;
    send_cell('0);
    send_cell(uniform_cell(Q_MAX, Q_MAX));
    send_cell(uniform_cell(Q_MIN, Q_MIN));
    send_cell(uniform_cell(32'hffffffff, '0));
    send_cell(uniform_cell(32'd1, '0));
    send_cell(uniform_cell(Q_ONE / 9, '0));
    send_cell(uniform_cell(Q_ONE / 9, Q_MAX));
    send_cell(uniform_cell(Q_ONE / 9, Q_MIN));
    for (int k = 0; k < 9; k++) begin
      d = '0;
      d[32*k +: 32] = Q_ONE;
      d[288 +: 32] = (k % 2) ? Q_ONE : 32'hf0000000;
      send_cell(d);
    end
    d = uniform_cell(Q_ONE / 9, '0);
    d[32 +: 32] = Q_MAX;
    send_cell(d);
    d = uniform_cell(32'd1, Q_MAX);
    d[0 +: 32] = Q_MAX;
    send_cell(d);
    d = uniform_cell(Q_ONE, '0);
    d[96 +: 32] = Q_MIN;
    send_cell(d);
    s_tvalid = 1'b0;
  endtask

  task automatic program_rates(input logic [31:0] relax, input logic [31:0] keep,
                               input logic [31:0] gain, input logic [31:0] gx,
                               input logic [31:0] gy);
    write_reg(REG_RELAX_RATE, relax);
    write_reg(REG_KEEP_RATE, keep);
    write_reg(REG_FORCE_GAIN, gain);
    write_reg(REG_GRAVITY_X, gx);
    write_reg(REG_GRAVITY_Y, gy);
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    no_idle = 1'b0;
    hold_req = 1'b0;
    cells_sent = 0;
    idle_cycles = 0;
    repeat (6) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    directed_cells();
    for (int phase = 0; phase < 6; phase++) begin
      drain();
      case (phase)
        1: program_rates(32'd109227, -32'sd43691, 32'd32768, small_signed(1 << 18),
                         small_signed(1 << 18));
        2: begin
          program_rates(32'd0, -32'sd65536, 32'd0, Q_MAX, Q_MIN);
          hold_req = 1'b1;
        end
        3: begin
          program_rates(32'd131072, 32'd65536, 32'd196608, Q_MIN, Q_MAX);
          no_idle = 1'b1;
        end
        4: begin
          no_idle = 1'b0;
          program_rates($urandom, $urandom, $urandom, $urandom, $urandom);
          write_reg(REG_UNUSED, $urandom);
        end
        5: program_rates(32'd65536, 32'd0, 32'd98304, small_signed(1 << 18),
                         small_signed(1 << 18));
        default: ;
      endcase
      repeat (CELLS_PER_PHASE) send_cell(random_cell());
    end
    drain();

    $display("sent %0d cells over 6 register settings, %0d results, %0d density faults",
             cells_sent, results_seen, faults_seen);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches", errors);
      $display("tb: failure");
    end
    $finish;
  end

endmodule
